// ===== design/tsgt_pkg.sv =====
// Shared types and codes for the tagged sorted group table.
package tsgt_pkg;

    // Operation codes
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_REM  = 2'd1;
    localparam logic [1:0] OP_ITER = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_IGN  = 2'd1;
    localparam logic [1:0] ST_END  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_SECTOR = 2'd0;
    localparam logic [1:0] CFG_LINE   = 2'd1;
    localparam logic [1:0] CFG_THING  = 2'd2;

    // Element kinds
    localparam logic [1:0] KIND_LAST = 2'd2;

    // Sequencer states
    typedef enum logic [10:0] {
        S_CLR  = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_LEN  = 11'b000_0000_0100,
        S_SCAN = 11'b000_0000_1000,
        S_DEC  = 11'b000_0001_0000,
        S_SHR  = 11'b000_0010_0000,
        S_SHW  = 11'b000_0100_0000,
        S_INS  = 11'b000_1000_0000,
        S_ITR  = 11'b001_0000_0000,
        S_ITW  = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } t_state;

endpackage

// ===== design/tagged_sorted_group_table_top.sv =====
// Tagged sorted group table: per kind and tag, a sorted duplicate-free id list.
// One item at a time. A tagged remove of a present id shifts the later entries down, and an
// add that inserts shifts the later entries up and ends with a final insert write. The time
// is set by the single entry-memory port that the scan and the shift loop both use. Global
// or malformed items skip the memories, and a stalled result keeps the block busy until it
// is taken. After reset, a clearing pass zeroes the group-length memory, one entry a cycle.
// No item is accepted during that pass. Configuration writes are taken at any time.
module tagged_sorted_group_table_top
    import tsgt_pkg::*;
#(
    parameter int TAG_COUNT   = 256,
    parameter int GROUP_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_kind,
    input  logic        i_is_global,
    input  logic [7:0]  i_tag,
    input  logic [15:0] i_element_id,
    input  logic [15:0] i_position,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_element_out,
    output logic [8:0]  o_distinct_tags
);

    localparam int MAP_N = (TAG_COUNT < 256) ? TAG_COUNT : 256;
    localparam int TAGW  = $clog2(MAP_N);
    localparam int SW    = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int LW    = $clog2(GROUP_DEPTH + 1);
    localparam int LAW   = 2 + TAGW;
    localparam int EAW   = 2 + TAGW + SW;

    // tag modulo TAG_COUNT, a constant table
    logic [TAGW-1:0] c_tmod [256];
    for (genvar gi = 0; gi < 256; gi++) begin : g_tmod
        assign c_tmod[gi] = TAGW'(gi % TAG_COUNT);
    end

    t_state r_state, n_state;

    logic [15:0]         r_bound [3];
    logic [1:0]          r_op, r_kind;
    logic [TAGW-1:0]     r_t;
    logic [ID_WIDTH-1:0] r_id;
    logic [15:0]         r_pos;
    logic [1:0]          r_k;
    logic [LW-1:0]       r_lens [3];
    logic [LW-1:0]       r_i, r_fpos, r_ins, r_dst;
    logic                r_found, r_have_ins;
    logic [1:0]          r_status;
    logic [15:0]         r_elem;
    logic [MAP_N-1:0]    r_map;
    logic [8:0]          r_total;
    logic [LAW:0]        r_clr;
    logic                r_out_valid;
    logic [1:0]          r_out_status;
    logic [15:0]         r_out_elem;
    logic [8:0]          r_out_tags;

    logic [LW-1:0]       cur_len;
    logic [LW-1:0]       itr_len;
    logic [LW+1:0]       sum_len;
    logic [LW-1:0]       scan_j;
    logic                in_acc, out_free;

    logic                len_we;
    logic [LAW-1:0]      len_waddr, len_raddr;
    logic [LW-1:0]       len_wdata, len_rd;
    logic                ent_we;
    logic [EAW-1:0]      ent_waddr, ent_raddr;
    logic [ID_WIDTH-1:0] ent_wdata, ent_rd;
    logic [LW-1:0]       ent_rslot, ent_wslot;

    // group length memory
    tsgt_ram #(.W(LW), .AW(LAW)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (len_raddr),
        .o_rdata (len_rd)
    );

    // group entry memory
    tsgt_ram #(.W(ID_WIDTH), .AW(EAW)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rd)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // length of the addressed kind
    always_comb begin
        case (r_kind)
            2'd0:    cur_len = r_lens[0];
            2'd1:    cur_len = r_lens[1];
            default: cur_len = r_lens[2];
        endcase
    end
    // last kind's length is still on the read port in the final length cycle
    assign itr_len = (r_kind == KIND_LAST) ? len_rd : cur_len;
    assign sum_len = (LW+2)'(r_lens[0]) + (LW+2)'(r_lens[1]) + (LW+2)'(r_lens[2]);
    assign scan_j  = r_i - LW'(1);

    // memory addressing
    always_comb begin
        len_raddr = {r_k, r_t};
        len_we    = 1'b0;
        len_waddr = {r_kind, r_t};
        len_wdata = (r_op == OP_ADD) ? cur_len + LW'(1) : cur_len - LW'(1);
        ent_rslot = r_i;
        ent_we    = 1'b0;
        ent_wslot = r_dst;
        ent_wdata = ent_rd;
        unique case (r_state)
            S_CLR: begin
                len_we    = 1'b1;
                len_waddr = r_clr[LAW-1:0];
                len_wdata = '0;
            end
            S_DEC: begin
                len_we = (r_op == OP_ADD) ? (!r_found && (cur_len < LW'(GROUP_DEPTH)))
                                          : r_found;
            end
            S_SHR: begin
                ent_rslot = (r_op == OP_ADD) ? r_dst - LW'(1) : r_dst + LW'(1);
            end
            S_SHW: begin
                ent_we = 1'b1;
            end
            S_INS: begin
                ent_we    = 1'b1;
                ent_wslot = r_ins;
                ent_wdata = r_id;
            end
            S_ITR: begin
                ent_rslot = LW'(r_pos[SW-1:0]);
            end
            default: ;
        endcase
        ent_raddr = {r_kind, r_t, ent_rslot[SW-1:0]};
        ent_waddr = {r_kind, r_t, ent_wslot[SW-1:0]};
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == (LAW+1)'(2**LAW - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    if (i_kind > KIND_LAST || i_operation > OP_ITER || i_is_global) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (r_k == 2'd3) begin
                    if (r_op == OP_ITER) begin
                        n_state = (r_pos < 16'(itr_len)) ? S_ITR : S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: if (r_i == cur_len) n_state = S_DEC;
            S_DEC: begin
                if (r_op == OP_ADD) begin
                    if (r_found || cur_len >= LW'(GROUP_DEPTH)) n_state = S_FIN;
                    else if (cur_len > r_ins)                   n_state = S_SHR;
                    else                                        n_state = S_INS;
                end else begin
                    if (!r_found)                          n_state = S_FIN;
                    else if (r_fpos + LW'(1) < cur_len)    n_state = S_SHR;
                    else                                   n_state = S_FIN;
                end
            end
            S_SHR: n_state = S_SHW;
            S_SHW: begin
                if (r_op == OP_ADD) begin
                    n_state = (r_dst - LW'(1) > r_ins) ? S_SHR : S_INS;
                end else begin
                    n_state = (r_dst + LW'(2) < cur_len) ? S_SHR : S_FIN;
                end
            end
            S_INS: n_state = S_FIN;
            S_ITR: n_state = S_ITW;
            S_ITW: n_state = S_FIN;
            S_FIN: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_map       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_bound[0]  <= '0;
            r_bound[1]  <= '0;
            r_bound[2]  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + (LAW+1)'(1);
            // config writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SECTOR: r_bound[0] <= i_cfg_data;
                    CFG_LINE:   r_bound[1] <= i_cfg_data;
                    CFG_THING:  r_bound[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            // tag map and count
            if (r_state == S_DEC) begin
                if (r_op == OP_ADD) begin
                    if (!r_found && cur_len < LW'(GROUP_DEPTH) && !r_map[r_t]) begin
                        r_map[r_t] <= 1'b1;
                        r_total    <= r_total + 9'd1;
                    end
                end else if (r_found && cur_len == LW'(1) &&
                             sum_len == (LW+2)'(1) && r_map[r_t]) begin
                    r_map[r_t] <= 1'b0;
                    r_total    <= r_total - 9'd1;
                end
            end
            // output register
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op     <= i_operation;
                r_kind   <= i_kind;
                r_t      <= c_tmod[i_tag];
                r_id     <= ID_WIDTH'(i_element_id);
                r_pos    <= i_position;
                r_k      <= '0;
                r_elem   <= '0;
                r_status <= ST_END;
                if (i_kind <= KIND_LAST && i_is_global) begin
                    if (i_operation == OP_ADD || i_operation == OP_REM) begin
                        r_status <= ST_IGN;
                    end else if (i_operation == OP_ITER) begin
                        case (i_kind)
                            2'd0: if (i_position < r_bound[0]) begin
                                r_status <= ST_OK;
                                r_elem   <= i_position;
                            end
                            2'd1: if (i_position < r_bound[1]) begin
                                r_status <= ST_OK;
                                r_elem   <= i_position;
                            end
                            default: if (i_position < r_bound[2]) begin
                                r_status <= ST_OK;
                                r_elem   <= i_position;
                            end
                        endcase
                    end
                end
            end
            S_LEN: begin
                r_k <= r_k + 2'd1;
                case (r_k)
                    2'd1:    r_lens[0] <= len_rd;
                    2'd2:    r_lens[1] <= len_rd;
                    2'd3:    r_lens[2] <= len_rd;
                    default: ;
                endcase
                r_i        <= '0;
                r_found    <= 1'b0;
                r_have_ins <= 1'b0;
            end
            S_SCAN: begin
                if (r_i == '0) r_ins <= cur_len;
                if (r_i != '0) begin
                    // shared compare: entry at scan_j against the item id
                    if (ent_rd == r_id && !r_found) begin
                        r_found <= 1'b1;
                        r_fpos  <= scan_j;
                    end
                    if (ent_rd > r_id && !r_have_ins) begin
                        r_have_ins <= 1'b1;
                        r_ins      <= scan_j;
                    end
                end
                r_i <= r_i + LW'(1);
            end
            S_DEC: begin
                if (r_op == OP_ADD) begin
                    r_dst    <= cur_len;
                    r_status <= r_found ? ST_IGN :
                                (cur_len >= LW'(GROUP_DEPTH)) ? ST_FULL : ST_OK;
                end else begin
                    r_dst    <= r_fpos;
                    r_status <= r_found ? ST_OK : ST_END;
                end
            end
            S_SHW: begin
                r_dst <= (r_op == OP_ADD) ? r_dst - LW'(1) : r_dst + LW'(1);
            end
            S_ITW: begin
                r_status <= ST_OK;
                r_elem   <= 16'(ent_rd);
            end
            S_FIN: begin
                if (out_free) begin
                    r_out_status <= r_status;
                    r_out_elem   <= r_elem;
                    r_out_tags   <= r_total;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_element_out   = r_out_elem;
    assign o_distinct_tags = r_out_tags;

endmodule

// ===== design/tsgt_ram.sv =====
// Simple dual-port memory: one write port, one registered read port.
module tsgt_ram #(
    parameter int W  = 16,
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [2**AW];
    logic [W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tsgt_checker.sv =====
// Port-level checks for the tagged sorted group table, bound to the top level.
module tsgt_checker
    import tsgt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [15:0] o_element_out,
    input logic [8:0]  o_distinct_tags
);

    // a held result keeps its status
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("held result changed");

    // the block is busy right after taking an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item taken without going busy");

    // failed results carry no element
    a_elem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_element_out == 16'd0)
        else $error("element on failed result");

    // tag count stays in range
    a_tags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_distinct_tags <= 9'd256)
        else $error("tag count out of range");

endmodule

bind tagged_sorted_group_table_top tsgt_checker u_tsgt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_element_out   (o_element_out),
    .o_distinct_tags (o_distinct_tags)
);
